FILE: design/dsbd_pkg.sv
// Package: shared constants, register indexes, CORDIC table and helper functions.
`timescale 1ns / 1ps
package dsbd_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_VELOCITY_LIMIT  = 3'd0;
  localparam logic [2:0] REG_STEER_LIMIT     = 3'd1;
  localparam logic [2:0] REG_INV_VEL_LAG     = 3'd2;
  localparam logic [2:0] REG_INV_STEER_LAG   = 3'd3;
  localparam logic [2:0] REG_INV_WHEELBASE   = 3'd4;
  localparam logic [2:0] REG_VEL_DELAY       = 3'd5;
  localparam logic [2:0] REG_STEER_DELAY     = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Reset values
  localparam logic [14:0] VELOCITY_LIMIT_RST = 15'd32767;
  localparam logic [14:0] STEER_LIMIT_RST    = 15'd32767;
  localparam logic [15:0] INV_LAG_RST        = 16'd256;
  localparam logic [15:0] INV_WHEELBASE_RST  = 16'd1365;

  localparam int MAX_DELAY_STEPS_DEF = 64;

  // Stream widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 104;

  // CORDIC start value (gain compensated, Q30) and steer angle scale
  localparam logic signed [33:0] CORDIC_X0   = 34'sd652032874;
  localparam logic signed [17:0] STEER_SCALE = 18'sd83443;
  localparam int CORDIC_STEPS = 16;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } cord_t;

  // Arctangent of 2^-i in 2^32-per-turn units
  function automatic logic [31:0] atan_lut(input logic [3:0] i);
    logic [31:0] r;
    unique case (i)
      4'd0:  r = 32'd536870912;
      4'd1:  r = 32'd316933406;
      4'd2:  r = 32'd167458907;
      4'd3:  r = 32'd85004756;
      4'd4:  r = 32'd42667331;
      4'd5:  r = 32'd21354465;
      4'd6:  r = 32'd10679838;
      4'd7:  r = 32'd5340245;
      4'd8:  r = 32'd2670163;
      4'd9:  r = 32'd1335087;
      4'd10: r = 32'd667544;
      4'd11: r = 32'd333772;
      4'd12: r = 32'd166886;
      4'd13: r = 32'd83443;
      4'd14: r = 32'd41722;
      4'd15: r = 32'd20861;
    endcase
    return r;
  endfunction

  // One CORDIC rotation step
  function automatic cord_t cord_step(input cord_t c, input logic [3:0] i);
    cord_t n;
    logic signed [32:0] a;
    a = $signed({1'b0, atan_lut(i)});
    if (c.z >= 0) begin
      n.x = c.x - (c.y >>> i);
      n.y = c.y + (c.x >>> i);
      n.z = c.z - a;
    end else begin
      n.x = c.x + (c.y >>> i);
      n.y = c.y - (c.x >>> i);
      n.z = c.z + a;
    end
    return n;
  endfunction

  // Round to nearest, ties away from zero, by a right shift of 30
  function automatic logic signed [65:0] round_sh30(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [65:0] r;
    mag = v[65] ? 66'(-v) : 66'(v);
    r = (mag + (66'd1 << 29)) >> 30;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

  // Round to nearest, ties away from zero, by a right shift of 8
  function automatic logic signed [65:0] round_sh8(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [65:0] r;
    mag = v[65] ? 66'(-v) : 66'(v);
    r = (mag + 66'd128) >> 8;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [65:0] v);
    logic [15:0] r;
    if (v > 66'sd32767) r = 16'h7fff;
    else if (v < -66'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [23:0] sat24(input logic signed [65:0] v);
    logic [23:0] r;
    if (v > 66'sd8388607) r = 24'h7fffff;
    else if (v < -66'sd8388608) r = 24'h800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

FILE: design/dsbd_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
`timescale 1ns / 1ps
module dsbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; a read of the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/delayed_steer_bicycle_derivative_unit.sv
// Top level: delayed-command bicycle model derivative unit.
`timescale 1ns / 1ps
// Usage:
//   Input items arrive on the s_axis group (tvalid/tready/tdata), one item per
//   simulation step. Each item pushes both commands into their delay lines and
//   produces exactly one result item on the m_axis group.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
//   by the user only while the block is idle; the block does not enforce this;
//   writes take effect for the next item. From accept to result valid an item
//   passes the delay-line read and clamp, 16 CORDIC steps, the shared
//   multiplier, divider setup, 25 bit-serial quotient steps and result load.
//   A new item is accepted only once the previous result is loaded into the
//   output register; the heading-rate divider and 16-step CORDIC set item rate.
//   Reset clears the delay-line valid bits and pointer (lines read as zero),
//   the control state and the registers to their defaults.
//   When the receiver stalls, the result holds in the output register and a
//   new item is still accepted and worked on; it waits in its last step until
//   the output register is free.
module delayed_steer_bicycle_derivative_unit #(
  parameter int MAX_DELAY_STEPS = dsbd_pkg::MAX_DELAY_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // velocity_command, steer_command, current_velocity, current_heading,
  // current_steer (lowest bits first)
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dsbd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // x_rate, y_rate, heading_rate, velocity_rate, steer_rate (lowest bits first)
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dsbd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [dsbd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dsbd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import dsbd_pkg::*;

  localparam int PTR_W = (MAX_DELAY_STEPS > 1) ? $clog2(MAX_DELAY_STEPS) : 1;
  localparam int DW    = (PTR_W + 1 > 7) ? PTR_W + 1 : 7;
  localparam logic [DW:0] MAX_EXT = (DW + 1)'(MAX_DELAY_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_CORD = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIVS = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Configuration registers
  logic [14:0] vlim_q, slim_q;
  logic [15:0] ivlag_q, islag_q, iwb_q;
  logic [6:0]  vdly_q, sdly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlim_q  <= VELOCITY_LIMIT_RST;
      slim_q  <= STEER_LIMIT_RST;
      ivlag_q <= INV_LAG_RST;
      islag_q <= INV_LAG_RST;
      iwb_q   <= INV_WHEELBASE_RST;
      vdly_q  <= 7'd0;
      sdly_q  <= 7'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VELOCITY_LIMIT: vlim_q  <= cfg_data_i[14:0];
        REG_STEER_LIMIT:    slim_q  <= cfg_data_i[14:0];
        REG_INV_VEL_LAG:    ivlag_q <= cfg_data_i;
        REG_INV_STEER_LAG:  islag_q <= cfg_data_i;
        REG_INV_WHEELBASE:  iwb_q   <= cfg_data_i;
        REG_VEL_DELAY:      vdly_q  <= cfg_data_i[6:0];
        REG_STEER_DELAY:    sdly_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  logic [2:0] state_q, state_d;
  logic [4:0] cnt_q;
  logic       in_acc;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Delay-line read addresses
  logic [DW-1:0]    vd, sd;
  logic [DW:0]      vraw, sraw;
  logic [PTR_W-1:0] vaddr, saddr, ptr_q;
  logic [MAX_DELAY_STEPS-1:0] vld_q;

  always_comb begin
    vd = (DW'(vdly_q) > DW'(MAX_DELAY_STEPS)) ? DW'(MAX_DELAY_STEPS) : DW'(vdly_q);
    sd = (DW'(sdly_q) > DW'(MAX_DELAY_STEPS)) ? DW'(MAX_DELAY_STEPS) : DW'(sdly_q);
    vraw = (DW + 1)'(ptr_q) + MAX_EXT - {1'b0, vd};
    sraw = (DW + 1)'(ptr_q) + MAX_EXT - {1'b0, sd};
    if (vraw >= MAX_EXT) vraw = vraw - MAX_EXT;
    if (sraw >= MAX_EXT) sraw = sraw - MAX_EXT;
    vaddr = vraw[PTR_W-1:0];
    saddr = sraw[PTR_W-1:0];
  end

  logic [15:0] vram_rd, sram_rd;

  dsbd_ram #(.WIDTH(16), .DEPTH(MAX_DELAY_STEPS)) u_vel_line (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (ptr_q),
    .wdata_i (s_axis_tdata[15:0]),
    .re_i    (in_acc),
    .raddr_i (vaddr),
    .rdata_o (vram_rd)
  );

  dsbd_ram #(.WIDTH(16), .DEPTH(MAX_DELAY_STEPS)) u_steer_line (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (ptr_q),
    .wdata_i (s_axis_tdata[31:16]),
    .re_i    (in_acc),
    .raddr_i (saddr),
    .rdata_o (sram_rd)
  );

  // Capture item, advance pointer, mark written slot
  logic signed [15:0] vcmd_q, scmd_q, vel_q, steer_q;
  logic [15:0]        head_q;
  logic               vrv_q, srv_q, vzero_q, szero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      vld_q <= '0;
    end else if (in_acc) begin
      vld_q[ptr_q] <= 1'b1;
      ptr_q <= (32'(ptr_q) == MAX_DELAY_STEPS - 1) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vcmd_q  <= s_axis_tdata[15:0];
      scmd_q  <= s_axis_tdata[31:16];
      vel_q   <= s_axis_tdata[47:32];
      head_q  <= s_axis_tdata[63:48];
      steer_q <= s_axis_tdata[79:64];
      vrv_q   <= vld_q[vaddr];
      srv_q   <= vld_q[saddr];
      vzero_q <= (vd == '0);
      szero_q <= (sd == '0);
    end
  end

  // Delayed command select and clamp, angle folding for CORDIC
  logic signed [15:0] vdel, sdel, vdes, sdes;
  logic signed [16:0] vl, sl;
  logic signed [33:0] sprod;
  logic [31:0]        hang, sang, hang_f, sang_f;
  logic               hflip, sflip;

  always_comb begin
    vdel = vzero_q ? vcmd_q : (vrv_q ? $signed(vram_rd) : 16'sd0);
    sdel = szero_q ? scmd_q : (srv_q ? $signed(sram_rd) : 16'sd0);
    vl = $signed({2'b00, vlim_q});
    sl = $signed({2'b00, slim_q});
    if (17'(vdel) > vl) vdes = vl[15:0];
    else if (17'(vdel) < -vl) vdes = 16'(-vl);
    else vdes = vdel;
    if (17'(sdel) > sl) sdes = sl[15:0];
    else if (17'(sdel) < -sl) sdes = 16'(-sl);
    else sdes = sdel;
    sprod  = steer_q * STEER_SCALE;
    hang   = {head_q, 16'd0};
    sang   = sprod[31:0];
    hflip  = hang[31] ^ hang[30];
    sflip  = sang[31] ^ sang[30];
    hang_f = hflip ? hang + 32'h8000_0000 : hang;
    sang_f = sflip ? sang + 32'h8000_0000 : sang;
  end

  // CORDIC registers, one unit per angle
  cord_t hc_q, sc_q;
  logic  hflip_q, sflip_q;
  logic signed [16:0] dv_q, ds_q;

  // Shared multiplier
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] prod_q;
  logic signed [33:0] hcos, hsin, scos, ssin;
  logic signed [33:0] wb_q;
  logic signed [65:0] num_q;
  logic [15:0]        xr_q, yr_q;
  logic [23:0]        vr_q, sr_q;

  always_comb begin
    hcos = hflip_q ? -hc_q.x : hc_q.x;
    hsin = hflip_q ? -hc_q.y : hc_q.y;
    scos = sflip_q ? -sc_q.x : sc_q.x;
    ssin = sflip_q ? -sc_q.y : sc_q.y;
    unique case (cnt_q[3:1])
      3'd0: begin mul_a = 34'(vel_q); mul_b = $signed({16'd0, iwb_q}); end
      3'd1: begin mul_a = wb_q;       mul_b = ssin[31:0]; end
      3'd2: begin mul_a = 34'(vel_q); mul_b = hcos[31:0]; end
      3'd3: begin mul_a = 34'(vel_q); mul_b = hsin[31:0]; end
      3'd4: begin mul_a = 34'(dv_q);  mul_b = $signed({16'd0, ivlag_q}); end
      default: begin mul_a = 34'(ds_q); mul_b = $signed({16'd0, islag_q}); end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Divider signals
  logic [65:0] an;
  logic [41:0] ad;
  logic [66:0] rem_q, dsr_q;
  logic [24:0] q_q;
  logic        ovf_q, neg_q, dzero_q, npos_q, nneg_q;
  logic [23:0] hr;

  always_comb begin
    an = num_q[65] ? 66'(-num_q) : 66'(num_q);
    ad = scos[33] ? {42'(-scos)} << 8 : {42'(scos)} << 8;
  end

  // Sequencer and datapath registers
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_INIT;
      S_INIT: state_d = S_CORD;
      S_CORD: if (cnt_q == 5'(CORDIC_STEPS - 1)) state_d = S_MUL;
      S_MUL:  if (cnt_q == 5'd11) state_d = S_DIVS;
      S_DIVS: state_d = S_DIV;
      S_DIV:  if (cnt_q == 5'd24) state_d = S_DONE;
      S_DONE: if (!m_axis_tvalid || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) cnt_q <= '0;
      else cnt_q <= cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      // Latch errors of the clamped delayed commands, seed both CORDIC units
      S_INIT: begin
        dv_q    <= 17'(vdes) - 17'(vel_q);
        ds_q    <= 17'(sdes) - 17'(steer_q);
        hflip_q <= hflip;
        sflip_q <= sflip;
        hc_q    <= '{x: CORDIC_X0, y: 34'sd0, z: 33'($signed(hang_f))};
        sc_q    <= '{x: CORDIC_X0, y: 34'sd0, z: 33'($signed(sang_f))};
      end
      // Rotate
      S_CORD: begin
        hc_q <= cord_step(hc_q, cnt_q[3:0]);
        sc_q <= cord_step(sc_q, cnt_q[3:0]);
      end
      // Consume products on odd cycles
      S_MUL: begin
        if (cnt_q[0]) begin
          unique case (cnt_q[3:1])
            3'd0: wb_q  <= prod_q[33:0];
            3'd1: num_q <= prod_q;
            3'd2: xr_q  <= sat16(round_sh30(prod_q));
            3'd3: yr_q  <= sat16(round_sh30(prod_q));
            3'd4: vr_q  <= sat24(round_sh8(prod_q));
            default: sr_q <= sat24(round_sh8(prod_q));
          endcase
        end
      end
      // Set up rounded restoring division
      S_DIVS: begin
        rem_q   <= 67'(an) + 67'(ad >> 1);
        dsr_q   <= 67'(ad) << 24;
        ovf_q   <= (67'(an) + 67'(ad >> 1)) >= (67'(ad) << 25);
        neg_q   <= num_q[65] ^ scos[33];
        dzero_q <= (scos == '0);
        npos_q  <= !num_q[65] && (num_q != '0);
        nneg_q  <= num_q[65];
        q_q     <= '0;
      end
      // One quotient bit per cycle
      S_DIV: begin
        if (rem_q >= dsr_q) begin
          rem_q <= rem_q - dsr_q;
          q_q   <= {q_q[23:0], 1'b1};
        end else begin
          q_q   <= {q_q[23:0], 1'b0};
        end
        dsr_q <= dsr_q >> 1;
      end
      default: ;
    endcase
  end

  // Sign and saturate heading rate, including the zero-divisor case
  always_comb begin
    if (dzero_q) begin
      hr = npos_q ? 24'h7fffff : (nneg_q ? 24'h800000 : 24'd0);
    end else if (ovf_q) begin
      hr = neg_q ? 24'h800000 : 24'h7fffff;
    end else if (!neg_q) begin
      hr = (q_q > 25'd8388607) ? 24'h7fffff : q_q[23:0];
    end else begin
      hr = (q_q > 25'd8388608) ? 24'h800000 : 24'(-q_q);
    end
  end

  // Output register
  logic        ovalid_q;
  logic [OUT_DATA_W-1:0] odata_q;
  logic        load;

  assign load = (state_q == S_DONE) && (!ovalid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) odata_q <= {sr_q, vr_q, hr, yr_q, xr_q};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule

FILE: design/dsbd_checker.sv
// Checker: port-level properties of the derivative unit, bound to the top level.
`timescale 1ns / 1ps
module dsbd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // One item at a time: busy after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted while busy");

  // A new result frees the input side
  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("not ready after result load");

  // No result right after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

endmodule

bind delayed_steer_bicycle_derivative_unit dsbd_checker u_dsbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
